FILE: src/swt_pkg.sv
// ----------------------------------------------------------------------------
// swt_pkg: shared types, constants and functions of the wave texture block
// Sizes of the layer ring, register codes, controller states and sine table.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int MAX_LAYERS = 256;
  localparam int COORD_BITS = 16;

  localparam int LAYER_AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int LCNT_W   = $clog2(MAX_LAYERS + 1);
  localparam int SUM_W    = $clog2(255 * MAX_LAYERS + 1);
  localparam int DCNT_W   = $clog2(SUM_W + 1);

  localparam int CNT_W   = 9;
  localparam int COLOR_W = 8;
  localparam int STEP_W  = 8;
  localparam int LIDX_W  = 8;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 9;
  localparam int PROD_W  = 18;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LAYER_COUNT = 3'd0,
    CFG_START_RED   = 3'd1,
    CFG_START_GREEN = 3'd2,
    CFG_START_BLUE  = 3'd3,
    CFG_END_RED     = 3'd4,
    CFG_END_GREEN   = 3'd5,
    CFG_END_BLUE    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_BLEND
  } state_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
  } layer_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // first quarter of the wave, 127 * sin scaled, truncated
  localparam logic [6:0] QUARTER_WAVE [0:64] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,  7'd24,
    7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,
    7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,  7'd70,  7'd73,  7'd75,
    7'd78,  7'd80,  7'd82,  7'd85,  7'd87,  7'd89,  7'd91,  7'd94,  7'd96,
    7'd98,  7'd100, 7'd102, 7'd103, 7'd105, 7'd107, 7'd108, 7'd110, 7'd112,
    7'd113, 7'd114, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122,
    7'd123, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126,
    7'd126, 7'd127
  };

  function automatic logic [7:0] sine_rom(input logic [7:0] i);
    logic [6:0] k;
    logic       up;
    if (i <= 8'd64) begin
      k  = i[6:0];
      up = 1'b1;
    end else if (i < 8'd128) begin
      k  = 7'(8'd128 - i);
      up = 1'b1;
    end else if (i <= 8'd192) begin
      k  = 7'(i - 8'd128);
      up = 1'b0;
    end else begin
      k  = 7'(8'd0 - i);
      up = 1'b0;
    end
    return up ? (8'd128 + {1'b0, QUARTER_WAVE[k]}) : (8'd128 - {1'b0, QUARTER_WAVE[k]});
  endfunction

  // from + prod / 255, quotient truncated toward zero; |prod| <= 255 * 255
  function automatic logic [COLOR_W-1:0] blend_out(input logic [COLOR_W-1:0] from,
                                                   input logic signed [PROD_W-1:0] prod);
    logic [16:0] mag;
    logic [16:0] acc;
    logic [7:0]  q;
    mag = prod[PROD_W-1] ? 17'(-prod) : 17'(prod);
    acc = mag + {8'd0, mag[16:8]} + 17'd1;
    q   = acc[15:8];
    return prod[PROD_W-1] ? (from - q) : (from + q);
  endfunction

endpackage

FILE: src/swt_in_if.sv
// ----------------------------------------------------------------------------
// swt_in_if: input item channel
// Valid/ready handshake carrying load and pixel items.
// ----------------------------------------------------------------------------
interface swt_in_if;
  import swt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [LIDX_W-1:0]     layer_index;
  logic [STEP_W-1:0]     step_x;
  logic [STEP_W-1:0]     step_y;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (
    output valid, command, layer_index, step_x, step_y, pixel_x, pixel_y,
    input  ready
  );

  modport sink (
    input  valid, command, layer_index, step_x, step_y, pixel_x, pixel_y,
    output ready
  );
endinterface

FILE: src/swt_out_if.sv
// ----------------------------------------------------------------------------
// swt_out_if: result item channel
// Valid/ready handshake carrying one blended color per pixel.
// ----------------------------------------------------------------------------
interface swt_out_if;
  import swt_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface

FILE: src/swt_cell.sv
// ----------------------------------------------------------------------------
// swt_cell: one cell of the layer ring
// Holds one layer's step pair and takes its neighbor's pair on each shift.
// ----------------------------------------------------------------------------
module swt_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  swt_pkg::layer_t d_in,
  output swt_pkg::layer_t q
);
  import swt_pkg::*;

  layer_t q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

FILE: src/swt_div.sv
// ----------------------------------------------------------------------------
// swt_div: serial restoring divider
// Divides the sine sum by the layer count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [swt_pkg::SUM_W-1:0]  dividend,
  input  logic [swt_pkg::LCNT_W-1:0] divisor,
  output logic [swt_pkg::SUM_W-1:0]  quotient,
  output swt_pkg::div_stat_t         stat
);
  import swt_pkg::*;

  logic [LCNT_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [LCNT_W:0]   trial;
  logic              fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = DCNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? LCNT_W'(trial - {1'b0, divisor}) : LCNT_W'(trial);
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: src/sum_of_sines_wave_texture_top.sv
// Pixel item: a full turn of the ring, a drain state, a divider start, the serial
// division and its done flag, then a multiply state and a blend state.
// Load item: the ring shifts until the target layer reaches the ring head.
// One item at a time; the blend holds while an older color still waits to be taken.
// Synchronous active-low reset clears control and settings; layer steps are not cleared.
// ----------------------------------------------------------------------------
// sum_of_sines_wave_texture_top: procedural sum-of-sines wave texture
// Layer steps circulate in a ring of cells; the ring head feeds the sine sum,
// a serial divider averages it and the result blends two colors.
// ----------------------------------------------------------------------------
module sum_of_sines_wave_texture_top (
  input  logic                       clk,
  input  logic                       rst_n,
  swt_in_if.sink                     in_ch,
  swt_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [swt_pkg::CFG_AW-1:0] cfg_index,
  input  logic [swt_pkg::CFG_DW-1:0] cfg_data
);
  import swt_pkg::*;

  localparam int LAST = MAX_LAYERS - 1;

  // configuration
  logic [CNT_W-1:0]   layer_count_r;
  logic [COLOR_W-1:0] start_col_r [3];
  logic [COLOR_W-1:0] end_col_r   [3];

  // control
  state_t             state_r, state_nxt;
  logic [LAYER_AW-1:0] pos_r, pos_nxt;
  logic [LAYER_AW-1:0] step_cnt_r;
  logic [LAYER_AW-1:0] tgt_r;
  logic               p_vld_r;
  logic               out_valid_r;

  // payload
  layer_t             ld_r;
  logic [7:0]         x_r, y_r;
  logic [LCNT_W-1:0]  layers_r;
  logic [7:0]         p_idx_r;
  logic               p_act_r;
  logic [SUM_W-1:0]   sum_r;
  logic [7:0]         t_r;
  logic signed [PROD_W-1:0] prod_r [3];
  logic [COLOR_W-1:0] out_col_r [3];

  // ring
  layer_t             cell_q [MAX_LAYERS];
  layer_t             tail_d;

  // control outputs
  logic               in_ready;
  logic               shift_en;
  logic               load_hit;
  logic               div_start;
  logic               out_load;
  logic               accept;
  logic               ring_end;

  logic [SUM_W-1:0]   quotient;
  div_stat_t          div_stat;
  logic [7:0]         head_idx;
  logic [7:0]         t_nxt;
  logic signed [8:0]  diff [3];
  logic signed [8:0]  t_s;

  assign accept   = in_ch.valid && in_ready;
  assign ring_end = (step_cnt_r == LAYER_AW'(LAST));

  // ---------------- configuration writes ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r  <= CNT_W'(1);
      start_col_r[0] <= '0;
      start_col_r[1] <= '0;
      start_col_r[2] <= '0;
      end_col_r[0]   <= '1;
      end_col_r[1]   <= '1;
      end_col_r[2]   <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LAYER_COUNT: layer_count_r  <= cfg_data[CNT_W-1:0];
        CFG_START_RED:   start_col_r[0] <= cfg_data[COLOR_W-1:0];
        CFG_START_GREEN: start_col_r[1] <= cfg_data[COLOR_W-1:0];
        CFG_START_BLUE:  start_col_r[2] <= cfg_data[COLOR_W-1:0];
        CFG_END_RED:     end_col_r[0]   <= cfg_data[COLOR_W-1:0];
        CFG_END_GREEN:   end_col_r[1]   <= cfg_data[COLOR_W-1:0];
        CFG_END_BLUE:    end_col_r[2]   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- controller ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == CMD_PIXEL) begin
            state_nxt = S_SUM;
          end else if (int'(in_ch.layer_index) < MAX_LAYERS) begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_LOAD:     if (pos_r == tgt_r) state_nxt = S_IDLE;
      S_SUM:      if (ring_end) state_nxt = S_DRAIN;
      S_DRAIN:    state_nxt = S_DIV_GO;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_stat.done) state_nxt = S_MUL;
      S_MUL:      state_nxt = S_BLEND;
      S_BLEND:    if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    shift_en  = 1'b0;
    load_hit  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_LOAD: begin
        shift_en = 1'b1;
        load_hit = (pos_r == tgt_r);
      end
      S_SUM:    shift_en = 1'b1;
      S_DIV_GO: div_start = 1'b1;
      S_BLEND:  out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ch.ready = in_ready;

  // ---------------- layer ring ----------------
  // Cell 0 holds layer pos_r; the head wraps to the tail unless a load replaces it.
  assign tail_d = load_hit ? ld_r : cell_q[0];

  for (genvar i = 0; i < MAX_LAYERS; i++) begin : g_ring
    if (i == LAST) begin : g_tail
      swt_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(tail_d), .q(cell_q[i]));
    end else begin : g_body
      swt_cell u_cell (.clk(clk), .shift_en(shift_en), .d_in(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  assign pos_nxt = (pos_r == LAYER_AW'(LAST)) ? '0 : pos_r + LAYER_AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      step_cnt_r <= '0;
      p_vld_r    <= 1'b0;
    end else begin
      if (shift_en) begin
        pos_r <= pos_nxt;
      end
      if (accept) begin
        step_cnt_r <= '0;
      end else if (state_r == S_SUM) begin
        step_cnt_r <= step_cnt_r + LAYER_AW'(1);
      end
      p_vld_r <= (state_r == S_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_r.step_x <= in_ch.step_x;
      ld_r.step_y <= in_ch.step_y;
      tgt_r       <= LAYER_AW'(in_ch.layer_index);
      x_r         <= in_ch.pixel_x[7:0];
      y_r         <= in_ch.pixel_y[7:0];
      if (layer_count_r == '0) begin
        layers_r <= LCNT_W'(1);
      end else if (int'(layer_count_r) > MAX_LAYERS) begin
        layers_r <= LCNT_W'(MAX_LAYERS);
      end else begin
        layers_r <= LCNT_W'(layer_count_r);
      end
    end
  end

  // ---------------- sine sum ----------------
  assign head_idx = 8'(x_r * cell_q[0].step_x) + 8'(y_r * cell_q[0].step_y);

  always_ff @(posedge clk) begin
    p_idx_r <= head_idx;
    p_act_r <= ((LCNT_W+1)'(pos_r) < (LCNT_W+1)'(layers_r));
    if (accept) begin
      sum_r <= '0;
    end else if (p_vld_r && p_act_r) begin
      sum_r <= sum_r + SUM_W'(sine_rom(p_idx_r));
    end
  end

  swt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (layers_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // ---------------- blend ----------------
  assign t_nxt = (quotient > SUM_W'(255)) ? 8'hFF : quotient[7:0];
  assign t_s   = $signed({1'b0, t_r});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({1'b0, end_col_r[c]}) - $signed({1'b0, start_col_r[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV_WAIT && div_stat.done) begin
      t_r <= t_nxt;
    end
    if (state_r == S_MUL) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= diff[c] * t_s;
      end
    end
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        out_col_r[c] <= blend_out(start_col_r[c], prod_r[c]);
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_col_r[0];
  assign out_ch.green = out_col_r[1];
  assign out_ch.blue  = out_col_r[2];

  // ---------------- assertions ----------------
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r)
    else $error("pending output item dropped");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (quotient <= SUM_W'(255)))
    else $error("average weight out of range");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_GO) |-> (int'(sum_r) <= 255 * int'(layers_r)))
    else $error("sine sum exceeds layer bound");

  a_ring_turn: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) && ring_end |=> (state_r == S_DRAIN) && !shift_en)
    else $error("ring kept shifting after a full turn");

endmodule

FILE: tb/sum_of_sines_wave_texture_top_test.sv
// ----------------------------------------------------------------------------
// sum_of_sines_wave_texture_top_test: self-checking bench for the wave texture
// Drives load and pixel items with random stalls on both channels and steps
// through several color and layer-count settings. Every color that comes out
// is compared with a color predicted from the bench's own copy of the layer
// steps and registers.
// ----------------------------------------------------------------------------
module sum_of_sines_wave_texture_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swt_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 300;

  localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 3'd7;

  // floor(127 * sin(k * pi / 128)), k = 0..64
  localparam int WAVE_QUARTER [0:64] = '{
    0,   3,   6,   9,   12,  15,  18,  21,  24,  27,  30,  33,  36,
    39,  42,  45,  48,  51,  54,  57,  59,  62,  65,  67,  70,  73,
    75,  78,  80,  82,  85,  87,  89,  91,  94,  96,  98,  100, 102,
    103, 105, 107, 108, 110, 112, 113, 114, 116, 117, 118, 119, 120,
    121, 122, 123, 123, 124, 125, 125, 126, 126, 126, 126, 126, 127
  };

  typedef struct {
    logic                  command;
    logic [LIDX_W-1:0]     layer_index;
    logic [STEP_W-1:0]     step_x;
    logic [STEP_W-1:0]     step_y;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } texture_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  class color_scoreboard;
    logic [CNT_W-1:0]  layer_count;
    color_t            start_color;
    color_t            end_color;
    logic [STEP_W-1:0] x_steps [MAX_LAYERS];
    logic [STEP_W-1:0] y_steps [MAX_LAYERS];
    int unsigned       wave [256];
    color_t            expected_colors [$];
    int                failures;

    function new();
      layer_count = CNT_W'(1);
      start_color = '{8'd0, 8'd0, 8'd0};
      end_color   = '{8'd255, 8'd255, 8'd255};
      failures    = 0;
      foreach (x_steps[k]) begin
        x_steps[k] = '0;
        y_steps[k] = '0;
      end
      // mirror the rising quarter, then flip the first half for the second
      for (int k = 0; k <= 64; k++) begin
        wave[k]       = 128 + WAVE_QUARTER[k];
        wave[128 - k] = 128 + WAVE_QUARTER[k];
      end
      for (int k = 0; k < 128; k++) wave[k + 128] = 256 - wave[k];
    endfunction

    function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        CFG_LAYER_COUNT: layer_count       = value;
        CFG_START_RED:   start_color.red   = value[COLOR_W-1:0];
        CFG_START_GREEN: start_color.green = value[COLOR_W-1:0];
        CFG_START_BLUE:  start_color.blue  = value[COLOR_W-1:0];
        CFG_END_RED:     end_color.red     = value[COLOR_W-1:0];
        CFG_END_GREEN:   end_color.green   = value[COLOR_W-1:0];
        CFG_END_BLUE:    end_color.blue    = value[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [COLOR_W-1:0] mix(logic [COLOR_W-1:0] from, logic [COLOR_W-1:0] to,
                                     int unsigned weight);
      int span;
      int level;
      span  = int'(to) - int'(from);
      level = int'(from) + span * int'(weight) / 255;
      return level[COLOR_W-1:0];
    endfunction

    function void note_item(texture_item_t it);
      int unsigned active;
      int unsigned total;
      int unsigned weight;
      int unsigned phase;
      color_t      c;
      if (it.command == CMD_LOAD) begin
        if (it.layer_index < MAX_LAYERS) begin
          x_steps[it.layer_index] = it.step_x;
          y_steps[it.layer_index] = it.step_y;
        end
        return;
      end
      active = (layer_count == 0) ? 1 : ((layer_count > MAX_LAYERS) ? MAX_LAYERS : layer_count);
      total  = 0;
      for (int k = 0; k < active; k++) begin
        phase = (it.pixel_x[7:0] * x_steps[k] + it.pixel_y[7:0] * y_steps[k]) % 256;
        total += wave[phase[7:0]];
      end
      weight = total / active;
      if (weight > 255) weight = 255;
      c.red   = mix(start_color.red, end_color.red, weight);
      c.green = mix(start_color.green, end_color.green, weight);
      c.blue  = mix(start_color.blue, end_color.blue, weight);
      expected_colors.push_back(c);
    endfunction

    function void compare(string channel, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, channel, want, got);
        failures++;
      end
    endfunction

    function void check_color(color_t got);
      color_t want;
      if (expected_colors.size() == 0) begin
        $display("%0t: color %0d/%0d/%0d arrived with none expected, expected nothing",
                 $time, got.red, got.green, got.blue);
        failures++;
        return;
      end
      want = expected_colors.pop_front();
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
    endfunction

    function int pending();
      return expected_colors.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  swt_in_if  in_ch ();
  swt_out_if out_ch ();

  sum_of_sines_wave_texture_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  color_scoreboard colors = new();
  int send_idle_pct = 22;
  int recv_idle_pct = 81;
  int quiet_cycles  = 0;
  bit layer_loaded [MAX_LAYERS];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      colors.check_color('{out_ch.red, out_ch.green, out_ch.blue});
    end
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sum_of_sines_wave_texture_top regression: fail");
      $finish;
    end
  end

  function automatic texture_item_t load_item(int unsigned idx, int unsigned sx, int unsigned sy);
    texture_item_t it;
    it.command     = CMD_LOAD;
    it.layer_index = LIDX_W'(idx);
    it.step_x      = STEP_W'(sx);
    it.step_y      = STEP_W'(sy);
    it.pixel_x     = COORD_BITS'($urandom_range(0, 16'hFFFF));
    it.pixel_y     = COORD_BITS'($urandom_range(0, 16'hFFFF));
    return it;
  endfunction

  function automatic texture_item_t pixel_item(int unsigned x, int unsigned y);
    texture_item_t it;
    it.command     = CMD_PIXEL;
    it.layer_index = LIDX_W'($urandom_range(0, 255));
    it.step_x      = STEP_W'($urandom_range(0, 255));
    it.step_y      = STEP_W'($urandom_range(0, 255));
    it.pixel_x     = COORD_BITS'(x);
    it.pixel_y     = COORD_BITS'(y);
    return it;
  endfunction

  function automatic color_t random_color();
    return '{COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
             COLOR_W'($urandom_range(0, 255))};
  endfunction

  // called at a falling edge; leaves valid high on return
  task automatic send_item(input texture_item_t it);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= it.command;
    in_ch.layer_index <= it.layer_index;
    in_ch.step_x      <= it.step_x;
    in_ch.step_y      <= it.step_y;
    in_ch.pixel_x     <= it.pixel_x;
    in_ch.pixel_y     <= it.pixel_y;
    do begin
      @(posedge clk);
      taken = in_ch.ready;
      if (taken) begin
        colors.note_item(it);
        if (it.command == CMD_LOAD) layer_loaded[it.layer_index] = 1'b1;
      end
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic wait_for_colors();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (colors.pending() != 0);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    colors.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned count, input color_t from, input color_t to,
                           input int items, input int s_idle, input int r_idle);
    int unsigned active;
    wait_for_colors();
    // a load may still be circling the ring after the last color
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_register(CFG_LAYER_COUNT, CFG_DW'(count));
    write_register(CFG_START_RED, CFG_DW'(from.red));
    write_register(CFG_START_GREEN, CFG_DW'(from.green));
    write_register(CFG_START_BLUE, CFG_DW'(from.blue));
    write_register(CFG_END_RED, CFG_DW'(to.red));
    write_register(CFG_END_GREEN, CFG_DW'(to.green));
    write_register(CFG_END_BLUE, CFG_DW'(to.blue));
    write_register(CFG_UNMAPPED, CFG_DW'($urandom_range(0, 511)));
    cfg_we <= 1'b0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    // load every layer a pixel will read before the first pixel
    active = (count == 0) ? 1 : ((count > MAX_LAYERS) ? MAX_LAYERS : count);
    for (int k = 0; k < active; k++) begin
      if (!layer_loaded[k]) send_item(load_item(k, $urandom_range(0, 255), $urandom_range(0, 255)));
    end
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 49) == 0) wait_for_colors();
      if ($urandom_range(0, 3) == 0) begin
        send_item(load_item($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255)));
      end else begin
        send_item(pixel_item($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF)));
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_LOAD;
    in_ch.layer_index = '0;
    in_ch.step_x      = '0;
    in_ch.step_y      = '0;
    in_ch.pixel_x     = '0;
    in_ch.pixel_y     = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items on the reset settings: one layer, black to white
    send_item(load_item(0, 0, 0));
    send_item(pixel_item(0, 0));
    send_item(pixel_item(16'hFFFF, 16'hFFFF));
    send_item(load_item(0, 255, 255));
    send_item(pixel_item(16'hFFFF, 0));
    send_item(pixel_item(0, 16'hFFFF));
    send_item(pixel_item(16'hFFFF, 16'hFFFF));
    send_item(pixel_item(16'h00FF, 16'hFF00));
    send_item(load_item(0, 1, 0));
    send_item(pixel_item(64, 0));
    send_item(pixel_item(192, 0));
    send_item(pixel_item(128, 0));
    // high coordinate bits must not matter
    send_item(pixel_item(16'h0140, 16'hABCD));
    send_item(load_item(255, 8'hAA, 8'h55));
    send_item(load_item(0, 8'h80, 8'h7F));
    send_item(pixel_item(1, 1));
    send_item(pixel_item(16'h8001, 16'h7FFE));

    run_phase(0, '{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}, 45, 22, 81);
    run_phase(5, random_color(), random_color(), 45, 22, 81);
    run_phase(256, random_color(), random_color(), 45, 81, 22);
    run_phase(511, '{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 45, 81, 22);
    run_phase(2, random_color(), random_color(), 45, 0, 0);
    run_phase(1, random_color(), random_color(), 45, 0, 0);

    wait_for_colors();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (colors.failures == 0 && colors.pending() == 0) begin
      $display("sum_of_sines_wave_texture_top regression: pass");
    end else begin
      $display("sum_of_sines_wave_texture_top regression: fail");
    end
    $finish;
  end

endmodule
